FILE: hdl/wrs_pkg.sv
`timescale 1ns / 1ps

package wrs_pkg;

  // Field and register widths.
  localparam int MAX_VARIANTS = 6;
  localparam int RAND_W       = 32;
  localparam int COUNT_W      = 3;
  localparam int WEIGHT_W     = 16;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int STATUS_W     = 2;

  // The remainder pipeline retires this many dividend bits per stage.
  localparam int STEP_BITS  = 4;
  localparam int DIV_STAGES = RAND_W / STEP_BITS;

  localparam logic [COUNT_W-1:0]  RESET_COUNT       = COUNT_W'(1);
  localparam logic [WEIGHT_W-1:0] RESET_WEIGHT_ZERO = WEIGHT_W'(1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WEIGHT_COUNT = 3'd0,
    REG_WEIGHT_ZERO  = 3'd1,
    REG_WEIGHT_ONE   = 3'd2,
    REG_WEIGHT_TWO   = 3'd3,
    REG_WEIGHT_THREE = 3'd4,
    REG_WEIGHT_FOUR  = 3'd5,
    REG_WEIGHT_FIVE  = 3'd6
  } reg_index_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_ZERO_SUM = 2'd2
  } status_t;

endpackage

FILE: hdl/wrs_req_if.sv
`timescale 1ns / 1ps

interface wrs_req_if;
  logic                             valid;
  logic                             ready;
  logic [wrs_pkg::RAND_W-1:0]       random_value;
  logic [wrs_pkg::COUNT_W-1:0]      offered_count;

  modport source (output valid, output random_value, output offered_count, input ready);
  modport sink   (input valid, input random_value, input offered_count, output ready);
endinterface

FILE: hdl/wrs_rsp_if.sv
`timescale 1ns / 1ps

interface wrs_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [wrs_pkg::COUNT_W-1:0]      chosen_index;
  logic [wrs_pkg::STATUS_W-1:0]     status;

  modport source (output valid, output chosen_index, output status, input ready);
  modport sink   (input valid, input chosen_index, input status, output ready);
endinterface

FILE: hdl/wrs_cfg.sv
`timescale 1ns / 1ps

module wrs_cfg #(
  parameter int MAX_VARIANTS = wrs_pkg::MAX_VARIANTS,
  parameter int SUM_W        = wrs_pkg::WEIGHT_W,
  parameter int LEVELS       = 0
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [wrs_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [wrs_pkg::CFG_DATA_W-1:0]         cfg_data,
  output logic [wrs_pkg::COUNT_W-1:0]            count,
  output logic [SUM_W-1:0]                       sum,
  output logic [MAX_VARIANTS-1:0][SUM_W-1:0]     cum
);

  localparam int CW = wrs_pkg::COUNT_W;
  localparam int IW = wrs_pkg::CFG_INDEX_W;

  logic [CW-1:0] weight_count;

  // Level 0 holds the weight registers themselves; each further level is one
  // step of a log-depth prefix sum, so the last level holds running totals.
  logic [MAX_VARIANTS-1:0][SUM_W-1:0] pfx [LEVELS+1];
  logic [SUM_W-1:0]                   sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_count <= wrs_pkg::RESET_COUNT;
      for (int i = 0; i < MAX_VARIANTS; i++) begin
        pfx[0][i] <= (i == 0) ? SUM_W'(wrs_pkg::RESET_WEIGHT_ZERO) : '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == wrs_pkg::REG_WEIGHT_COUNT) begin
        weight_count <= cfg_data[CW-1:0];
      end
      for (int i = 0; i < MAX_VARIANTS; i++) begin
        if (cfg_index == IW'(wrs_pkg::REG_WEIGHT_ZERO + i)) begin
          pfx[0][i] <= SUM_W'(cfg_data[wrs_pkg::WEIGHT_W-1:0]);
        end
      end
    end
    for (int j = 0; j < LEVELS; j++) begin
      for (int i = 0; i < MAX_VARIANTS; i++) begin
        if (i >= (1 << j)) begin
          pfx[j+1][i] <= pfx[j][i] + pfx[j][i - (1 << j)];
        end else begin
          pfx[j+1][i] <= pfx[j][i];
        end
      end
    end
  end

  assign count = (weight_count > CW'(MAX_VARIANTS)) ? CW'(MAX_VARIANTS) : weight_count;
  assign cum   = pfx[LEVELS];

  // The total is the running sum at the last counted variant.
  always_comb begin
    sum_next = '0;
    for (int i = 0; i < MAX_VARIANTS; i++) begin
      if (count == CW'(i + 1)) begin
        sum_next = cum[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
  end

endmodule

FILE: hdl/wrs_mod.sv
`timescale 1ns / 1ps

module wrs_mod #(
  parameter int SUM_W      = wrs_pkg::WEIGHT_W,
  parameter int PRE_STAGES = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [wrs_pkg::RAND_W-1:0]        in_value,
  input  logic [wrs_pkg::COUNT_W-1:0]       in_tag,
  input  logic [SUM_W-1:0]                  divisor,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [SUM_W-1:0]                  out_rem,
  output logic [wrs_pkg::COUNT_W-1:0]       out_tag
);

  localparam int RW  = wrs_pkg::RAND_W;
  localparam int SB  = wrs_pkg::STEP_BITS;
  localparam int NST = 1 + PRE_STAGES + wrs_pkg::DIV_STAGES;

  logic                          vld [NST];
  logic                          rdy [NST+1];
  logic [SUM_W-1:0]              rem [NST];
  logic [RW-1:0]                 dvd [NST];
  logic [wrs_pkg::COUNT_W-1:0]   tag [NST];

  // Restoring remainder over SB dividend bits, most significant first.
  function automatic logic [SUM_W-1:0] rem_step(input logic [SUM_W-1:0] r_in,
                                                input logic [SB-1:0]    bits,
                                                input logic [SUM_W-1:0] dvs);
    logic [SUM_W:0]   t;
    logic [SUM_W-1:0] r;
    r = r_in;
    for (int b = SB - 1; b >= 0; b--) begin
      t = {r, bits[b]};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
      end
      r = t[SUM_W-1:0];
    end
    return r;
  endfunction

  assign rdy[NST] = out_ready;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    assign rdy[k] = !vld[k] || rdy[k+1];

    if (k == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld[k] <= in_valid;
        end
        if (rdy[k] && in_valid) begin
          rem[k] <= '0;
          dvd[k] <= in_value;
          tag[k] <= in_tag;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end

      if (k <= PRE_STAGES) begin : g_align
        always_ff @(posedge clk) begin
          if (rdy[k] && vld[k-1]) begin
            rem[k] <= rem[k-1];
            dvd[k] <= dvd[k-1];
            tag[k] <= tag[k-1];
          end
        end
      end else begin : g_div
        always_ff @(posedge clk) begin
          if (rdy[k] && vld[k-1]) begin
            rem[k] <= rem_step(rem[k-1], dvd[k-1][RW-1 -: SB], divisor);
            dvd[k] <= {dvd[k-1][RW-SB-1:0], SB'(0)};
            tag[k] <= tag[k-1];
          end
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NST-1];
  assign out_rem   = rem[NST-1];
  assign out_tag   = tag[NST-1];

endmodule

FILE: hdl/wrs_pick.sv
`timescale 1ns / 1ps

module wrs_pick #(
  parameter int MAX_VARIANTS = wrs_pkg::MAX_VARIANTS,
  parameter int SUM_W        = wrs_pkg::WEIGHT_W
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [SUM_W-1:0]                      sample,
  input  logic [wrs_pkg::COUNT_W-1:0]           offered,
  input  logic [wrs_pkg::COUNT_W-1:0]           count,
  input  logic [SUM_W-1:0]                      sum,
  input  logic [MAX_VARIANTS-1:0][SUM_W-1:0]    cum,
  wrs_rsp_if.source                             rsp
);

  localparam int CW = wrs_pkg::COUNT_W;

  logic [MAX_VARIANTS-1:0] hit;
  logic [CW-1:0]           pick;
  logic [CW-1:0]           chosen_next;
  wrs_pkg::status_t        status_next;

  // The first variant whose running total passes the sample wins.
  always_comb begin
    for (int i = 0; i < MAX_VARIANTS; i++) begin
      hit[i] = (CW'(i) < count) && (sample < cum[i]);
    end
    pick = '0;
    for (int i = MAX_VARIANTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        pick = CW'(i);
      end
    end
  end

  // A zero total is a set-up fault and outranks a count mismatch.
  always_comb begin
    priority if (sum == '0) begin
      status_next = wrs_pkg::STATUS_ZERO_SUM;
      chosen_next = '0;
    end else if (offered != count) begin
      status_next = wrs_pkg::STATUS_MISMATCH;
      chosen_next = '0;
    end else begin
      status_next = wrs_pkg::STATUS_OK;
      chosen_next = pick;
    end
  end

  assign in_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (in_ready) begin
      rsp.valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      rsp.chosen_index <= chosen_next;
      rsp.status       <= status_next;
    end
  end

endmodule

FILE: hdl/weighted_random_selector_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Transfer when          Payload
// req       in         req.valid & req.ready  random_value[31:0], offered_count[2:0]
// rsp       out        rsp.valid & rsp.ready  chosen_index[2:0], status[1:0]
// cfg       in         cfg_write              cfg_index[2:0], cfg_data[15:0]
//
// One request transfer is taken per cycle while no stall backs up the pipeline;
// each gives one response transfer. A request passes through the input register,
// the alignment stages that cover the weight prefix-sum registers, the
// eight-stage remainder pipeline, four dividend bits per stage, and the
// response output register.
// Reset is synchronous: it empties the pipeline and loads the reset weights.
// A full stage holds while its successor cannot accept, so a stall drops nothing
// and bubbles close up; while a response waits, requests fill the empty stages.

module weighted_random_selector_unit #(
  parameter int MAX_VARIANTS = wrs_pkg::MAX_VARIANTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [wrs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [wrs_pkg::CFG_DATA_W-1:0]    cfg_data,
  wrs_req_if.sink                           req,
  wrs_rsp_if.source                         rsp
);

  // Running totals of up to MAX_VARIANTS 16-bit weights.
  localparam int SUM_W  = wrs_pkg::WEIGHT_W + $clog2(MAX_VARIANTS);
  // Register levels in the weight prefix-sum tree.
  localparam int LEVELS = $clog2(MAX_VARIANTS);
  // The total reaches its register in the cycle after the last prefix level.
  // Requests pass through alignment stages that cover the prefix levels and that
  // register before the first remainder step reads it, so a request that follows a
  // register write right away sees the new weights. The same holds for the cycles just after reset.
  localparam int PRE_STAGES = LEVELS + 1;

  logic [wrs_pkg::COUNT_W-1:0]         count;
  logic [SUM_W-1:0]                    sum;
  logic [MAX_VARIANTS-1:0][SUM_W-1:0]  cum;

  logic                                mod_valid;
  logic                                mod_ready;
  logic [SUM_W-1:0]                    mod_rem;
  logic [wrs_pkg::COUNT_W-1:0]         mod_tag;

  // Configuration registers and the derived running totals.
  wrs_cfg #(
    .MAX_VARIANTS (MAX_VARIANTS),
    .SUM_W        (SUM_W),
    .LEVELS       (LEVELS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .count     (count),
    .sum       (sum),
    .cum       (cum)
  );

  // Reduces the random word modulo the weight total. The offered count rides
  // along as a tag so the status can be decided at the end.
  wrs_mod #(
    .SUM_W      (SUM_W),
    .PRE_STAGES (PRE_STAGES)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_value  (req.random_value),
    .in_tag    (req.offered_count),
    .divisor   (sum),
    .out_valid (mod_valid),
    .out_ready (mod_ready),
    .out_rem   (mod_rem),
    .out_tag   (mod_tag)
  );

  // Compares the sample against the running totals, settles the status and
  // holds the response in the output register.
  wrs_pick #(
    .MAX_VARIANTS (MAX_VARIANTS),
    .SUM_W        (SUM_W)
  ) u_pick (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mod_valid),
    .in_ready (mod_ready),
    .sample   (mod_rem),
    .offered  (mod_tag),
    .count    (count),
    .sum      (sum),
    .cum      (cum),
    .rsp      (rsp)
  );

endmodule

FILE: sim/weighted_random_selector_unit_tb.sv
`timescale 1ns / 1ps

module weighted_random_selector_unit_tb;

  localparam int MAX_VARIANTS = wrs_pkg::MAX_VARIANTS;
  localparam int RAND_W       = wrs_pkg::RAND_W;
  localparam int COUNT_W      = wrs_pkg::COUNT_W;
  localparam int WEIGHT_W     = wrs_pkg::WEIGHT_W;
  localparam int CFG_INDEX_W  = wrs_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W   = wrs_pkg::CFG_DATA_W;

  // The pipeline is 14 deep at six variants. The tail wait covers it with margin.
  localparam int unsigned DRAIN_TAIL_CYCLES = 40;
  // The long receiver hold-off that backs the pipeline up into the request side.
  localparam int unsigned RSP_HOLD_CYCLES   = 300;
  // The longest correct stretch without a transfer is the receiver hold-off.
  // The limit is several times that.
  localparam int unsigned WATCHDOG_LIMIT    = 2000;
  localparam int unsigned NUM_PHASES        = 16;
  localparam int unsigned PICKS_PER_PHASE   = 100;
  // Register index 7 decodes to nothing. Writes to it must leave every weight alone.
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_SPARE = 3'd7;

  // One predicted response: the variant picked and the status that goes with it.
  typedef struct packed {
    logic [COUNT_W-1:0] chosen_index;
    wrs_pkg::status_t   status;
  } pick_t;

  // One row of the directed sequence. A row is either a register write or a
  // pick request. A pick row carries a typed-in result only where the answer
  // is obvious. Every other row is predicted.
  typedef struct {
    bit                    is_write;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_data;
    logic [RAND_W-1:0]      random_value;
    logic [COUNT_W-1:0]     offered_count;
    bit                    typed;
    pick_t                 pick;
  } vector_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  wrs_req_if req_if ();
  wrs_rsp_if rsp_if ();

  weighted_random_selector_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  // This is a private copy of the register file that the predictor works from.
  // It changes only while the block is idle, so in-flight picks never see a
  // mixed configuration.
  logic [COUNT_W-1:0]  cfg_count;
  logic [WEIGHT_W-1:0] cfg_weight [MAX_VARIANTS];

  // These are the expected responses, oldest first. An entry is appended when
  // its request transfer happens.
  pick_t pick_queue [$];
  vector_t directed_vectors [$];

  int unsigned fail_count;
  int unsigned quiet_cycles;
  bit          quiet_phase;       // No idling on either side while set.
  bit          rsp_hold_request;  // Asks the receiver for one long hold-off.

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A weight count above the variant limit saturates. That saturated count is
  // what the sum uses and what the offered count is compared against.
  function automatic int unsigned live_count();
    return (cfg_count > MAX_VARIANTS) ? MAX_VARIANTS : int'(cfg_count);
  endfunction

  function automatic int unsigned weight_total();
    int unsigned total;
    total = 0;
    for (int i = 0; i < live_count(); i++) total += cfg_weight[i];
    return total;
  endfunction

  // Roulette wheel: the random word is reduced modulo the weight sum. The pick
  // is the first variant whose running sum passes the reduced sample. A zero
  // sum is reported before a count mismatch. Neither fault picks a variant.
  function automatic pick_t predict_pick(input logic [RAND_W-1:0] rnd,
                                         input logic [COUNT_W-1:0] offered);
    pick_t       result;
    int unsigned total;
    int unsigned sample;
    int unsigned running;
    bit          found;
    result.chosen_index = '0;
    result.status       = wrs_pkg::STATUS_OK;
    total = weight_total();
    if (total == 0) begin
      result.status = wrs_pkg::STATUS_ZERO_SUM;
    end else if (offered != live_count()) begin
      result.status = wrs_pkg::STATUS_MISMATCH;
    end else begin
      sample  = rnd % total;
      running = 0;
      found   = 1'b0;
      for (int i = 0; i < live_count(); i++) begin
        running += cfg_weight[i];
        if (!found && sample < running) begin
          result.chosen_index = COUNT_W'(i);
          found = 1'b1;
        end
      end
    end
    return result;
  endfunction

  // Most idle stretches are short and a few are long. In a quiet phase there
  // are none.
  function automatic int unsigned idle_length();
    int unsigned roll;
    if (quiet_phase) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_write(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    vector_t v;
    v = '{default: '0};
    v.is_write  = 1'b1;
    v.reg_index = idx;
    v.reg_data  = data;
    directed_vectors = {directed_vectors, v};
  endfunction

  function automatic void add_pick(input logic [RAND_W-1:0] rnd,
                                   input logic [COUNT_W-1:0] cnt);
    vector_t v;
    v = '{default: '0};
    v.random_value  = rnd;
    v.offered_count = cnt;
    directed_vectors = {directed_vectors, v};
  endfunction

  function automatic void add_typed_pick(input logic [RAND_W-1:0] rnd,
                                         input logic [COUNT_W-1:0] cnt,
                                         input logic [COUNT_W-1:0] idx,
                                         input wrs_pkg::status_t st);
    vector_t v;
    v = '{default: '0};
    v.random_value      = rnd;
    v.offered_count     = cnt;
    v.typed             = 1'b1;
    v.pick.chosen_index = idx;
    v.pick.status       = st;
    directed_vectors = {directed_vectors, v};
  endfunction

  // The write enable is high for a single cycle. It then stays low until the task returns,
  // so back-to-back writes never lower and raise the enable in the same step.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == wrs_pkg::REG_WEIGHT_COUNT) begin
      cfg_count = data[COUNT_W-1:0];
    end else if (idx <= wrs_pkg::REG_WEIGHT_FIVE) begin
      cfg_weight[idx - 1] = data;
    end
    @(posedge clk);
  endtask

  // Offer one pick and hold it until the transfer. The expected response is
  // queued at the transfer edge. After the transfer, valid stays high unless a
  // gap follows, so back-to-back picks keep valid asserted.
  task automatic offer_pick(input logic [RAND_W-1:0] rnd, input logic [COUNT_W-1:0] cnt,
                            input pick_t want);
    int unsigned gap;
    req_if.valid         <= 1'b1;
    req_if.random_value  <= rnd;
    req_if.offered_count <= cnt;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pick_queue = {pick_queue, want};
    gap = idle_length();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every outstanding response has arrived. Once
  // the queue is empty, the pipeline is empty too, because every pick makes
  // exactly one response.
  task automatic drain_picks();
    req_if.valid <= 1'b0;
    while (pick_queue.size() != 0) @(posedge clk);
  endtask

  // Receiver: check each response transfer against the oldest expectation,
  // then choose ready for the next cycle. A hold request overrides everything
  // else and keeps ready low for a long stretch, counted here.
  initial begin
    int unsigned stall_left;
    pick_t       want;
    rsp_if.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) begin
        if (pick_queue.size() == 0) begin
          $error("response transfer with no pick outstanding: chosen_index %0d status %0d",
                 rsp_if.chosen_index, rsp_if.status);
          fail_count++;
        end else begin
          want = pick_queue.pop_front();
          if (rsp_if.chosen_index !== want.chosen_index) begin
            $error("chosen_index: expected %0d, actual %0d",
                   want.chosen_index, rsp_if.chosen_index);
            fail_count++;
          end
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
            fail_count++;
          end
        end
      end
      if (rsp_hold_request) begin
        rsp_if.ready <= 1'b0;
        rsp_hold_request = 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
      end else if (stall_left != 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        stall_left = idle_length();
      end
    end
  end

  // Watchdog: a healthy run never goes this long without a transfer on either
  // channel.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [RAND_W-1:0]  rnd;
    logic [COUNT_W-1:0] cnt;
    logic [COUNT_W-1:0] new_count;
    logic [WEIGHT_W-1:0] new_weight;
    pick_t       want;
    vector_t     v;
    int unsigned total;
    int unsigned live;
    int unsigned lane;
    int unsigned prefix;
    int unsigned roll;

    rst                  <= 1'b1;
    cfg_write            <= 1'b0;
    cfg_index            <= wrs_pkg::REG_WEIGHT_COUNT;
    cfg_data             <= '0;
    req_if.valid         <= 1'b0;
    req_if.random_value  <= '0;
    req_if.offered_count <= '0;
    fail_count       = 0;
    quiet_cycles     = 0;
    quiet_phase      = 1'b0;
    rsp_hold_request = 1'b0;

    // After reset, variant zero has weight one and the count is one. Every
    // other weight is zero.
    cfg_count = wrs_pkg::RESET_COUNT;
    for (int i = 0; i < MAX_VARIANTS; i++) cfg_weight[i] = '0;
    cfg_weight[0] = wrs_pkg::RESET_WEIGHT_ZERO;

    // Reset state: one live variant, so any word picks variant zero.
    add_typed_pick(32'h0000_0000, 3'd1, 3'd0, wrs_pkg::STATUS_OK);
    add_typed_pick(32'hFFFF_FFFF, 3'd1, 3'd0, wrs_pkg::STATUS_OK);
    add_typed_pick(32'h0000_0000, 3'd0, 3'd0, wrs_pkg::STATUS_MISMATCH);
    add_typed_pick(32'h5A5A_5A5A, 3'd7, 3'd0, wrs_pkg::STATUS_MISMATCH);
    // All six weights at maximum: the largest sum the block can form.
    add_write(wrs_pkg::REG_WEIGHT_COUNT, 16'd6);
    add_write(wrs_pkg::REG_WEIGHT_ZERO,  16'hFFFF);
    add_write(wrs_pkg::REG_WEIGHT_ONE,   16'hFFFF);
    add_write(wrs_pkg::REG_WEIGHT_TWO,   16'hFFFF);
    add_write(wrs_pkg::REG_WEIGHT_THREE, 16'hFFFF);
    add_write(wrs_pkg::REG_WEIGHT_FOUR,  16'hFFFF);
    add_write(wrs_pkg::REG_WEIGHT_FIVE,  16'hFFFF);
    add_typed_pick(32'h0000_0000, 3'd6, 3'd0, wrs_pkg::STATUS_OK);
    add_pick(32'hFFFF_FFFF, 3'd6);
    add_pick(32'h0005_FFF9, 3'd6);
    add_typed_pick(32'hFFFF_FFFF, 3'd5, 3'd0, wrs_pkg::STATUS_MISMATCH);
    // A count of seven saturates to six, so six must be offered.
    add_write(wrs_pkg::REG_WEIGHT_COUNT, 16'd7);
    add_pick(32'hA5A5_A5A5, 3'd6);
    add_typed_pick(32'h0000_0000, 3'd7, 3'd0, wrs_pkg::STATUS_MISMATCH);
    // An empty weight list sums to zero.
    add_write(wrs_pkg::REG_WEIGHT_COUNT, 16'd0);
    add_typed_pick(32'h0000_0000, 3'd0, 3'd0, wrs_pkg::STATUS_ZERO_SUM);
    add_typed_pick(32'hFFFF_FFFF, 3'd6, 3'd0, wrs_pkg::STATUS_ZERO_SUM);
    // All live weights are zero. The zero sum wins over a count mismatch.
    add_write(wrs_pkg::REG_WEIGHT_COUNT, 16'd3);
    add_write(wrs_pkg::REG_WEIGHT_ZERO,  16'd0);
    add_write(wrs_pkg::REG_WEIGHT_ONE,   16'd0);
    add_write(wrs_pkg::REG_WEIGHT_TWO,   16'd0);
    add_typed_pick(32'h0000_1234, 3'd3, 3'd0, wrs_pkg::STATUS_ZERO_SUM);
    add_typed_pick(32'h0000_1234, 3'd2, 3'd0, wrs_pkg::STATUS_ZERO_SUM);
    // Only variant two carries weight. A write to the spare index must not land.
    add_write(wrs_pkg::REG_WEIGHT_TWO, 16'd5);
    add_write(REG_INDEX_SPARE, 16'hFFFF);
    add_typed_pick(32'hFFFF_FFFF, 3'd3, 3'd2, wrs_pkg::STATUS_OK);
    // Zero weights between two live variants must never be picked.
    add_write(wrs_pkg::REG_WEIGHT_COUNT, 16'd4);
    add_write(wrs_pkg::REG_WEIGHT_ZERO,  16'd1);
    add_write(wrs_pkg::REG_WEIGHT_TWO,   16'd0);
    add_write(wrs_pkg::REG_WEIGHT_THREE, 16'd1);
    add_typed_pick(32'd2, 3'd4, 3'd0, wrs_pkg::STATUS_OK);
    add_typed_pick(32'd3, 3'd4, 3'd3, wrs_pkg::STATUS_OK);
    // Graded weights 1..6 (sum 21). These probe the ends of the wheel.
    add_write(wrs_pkg::REG_WEIGHT_COUNT, 16'd6);
    add_write(wrs_pkg::REG_WEIGHT_ZERO,  16'd1);
    add_write(wrs_pkg::REG_WEIGHT_ONE,   16'd2);
    add_write(wrs_pkg::REG_WEIGHT_TWO,   16'd3);
    add_write(wrs_pkg::REG_WEIGHT_THREE, 16'd4);
    add_write(wrs_pkg::REG_WEIGHT_FOUR,  16'd5);
    add_write(wrs_pkg::REG_WEIGHT_FIVE,  16'd6);
    add_pick(32'd20, 3'd6);
    add_pick(32'd0, 3'd6);
    add_pick(32'd41, 3'd6);
    add_pick(32'd10, 3'd6);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Register writes wait until the block has gone idle.
    foreach (directed_vectors[n]) begin
      v = directed_vectors[n];
      if (v.is_write) begin
        drain_picks();
        write_register(v.reg_index, v.reg_data);
      end else begin
        want = v.typed ? v.pick : predict_pick(v.random_value, v.offered_count);
        offer_pick(v.random_value, v.offered_count, want);
      end
    end

    // Random part. Each phase loads a fresh configuration while idle, then
    // runs a batch of picks. Most picks offer the right count, so they reach
    // the remainder and prefix logic. The rest test the mismatch path.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_picks();
      quiet_phase = (phase % 4 == 2);

      roll = $urandom_range(0, 19);
      if (roll == 0) new_count = 3'd0;
      else if (roll == 1) new_count = 3'd7;
      else new_count = COUNT_W'($urandom_range(1, MAX_VARIANTS));
      // The upper data bits of a count write are junk and must be dropped.
      write_register(wrs_pkg::REG_WEIGHT_COUNT, {13'($urandom), new_count});
      for (int i = 0; i < MAX_VARIANTS; i++) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) new_weight = '0;
        else if (roll == 1) new_weight = '1;
        else if (roll < 5) new_weight = WEIGHT_W'($urandom_range(1, 8));
        else new_weight = WEIGHT_W'($urandom);
        write_register(CFG_INDEX_W'(wrs_pkg::REG_WEIGHT_ZERO) + CFG_INDEX_W'(i), new_weight);
      end
      if ($urandom_range(0, 3) == 0) write_register(REG_INDEX_SPARE, CFG_DATA_W'($urandom));

      live  = live_count();
      total = weight_total();
      for (int n = 0; n < PICKS_PER_PHASE; n++) begin
        // Hold the receiver off for a long stretch. The sender keeps
        // offering, so the pipeline fills and stalls the request side.
        if (phase == 3 && n == 30) rsp_hold_request = 1'b1;
        // Here the sender pauses until every response is back.
        if (phase == 5 && n == 50) drain_picks();

        roll = $urandom_range(0, 99);
        if (roll < 50 || total == 0) begin
          rnd = $urandom;
        end else if (roll < 80) begin
          // Land exactly on, or just below, a running-sum boundary, some way
          // up the 32-bit range.
          lane   = $urandom_range(0, live - 1);
          prefix = 0;
          for (int i = 0; i <= lane; i++) prefix += cfg_weight[i];
          rnd = total * $urandom_range(0, 32'hFFFF_FFFF / total) + prefix - 1
                + $urandom_range(0, 1);
        end else if (roll < 90) begin
          rnd = ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        end else begin
          rnd = $urandom_range(0, 2 * total);
        end
        cnt = ($urandom_range(0, 99) < 85) ? COUNT_W'(live) : COUNT_W'($urandom_range(0, 7));
        offer_pick(rnd, cnt, predict_pick(rnd, cnt));
      end
    end

    drain_picks();
    repeat (DRAIN_TAIL_CYCLES) @(posedge clk);
    if (pick_queue.size() != 0) begin
      $error("%0d responses never arrived", pick_queue.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/wrs_pkg.sv
hdl/wrs_req_if.sv
hdl/wrs_rsp_if.sv
hdl/wrs_cfg.sv
hdl/wrs_mod.sv
hdl/wrs_pick.sv
hdl/weighted_random_selector_unit.sv
sim/weighted_random_selector_unit_tb.sv
